// ----- src/fnec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnec_pkg: shared types and constants
// Store depths, operation codes, register indexes and the command record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package fnec_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int FACET_DEPTH  = 8192;
    localparam int VA_W         = $clog2(VERTEX_DEPTH);
    localparam int FA_W         = $clog2(FACET_DEPTH);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QA_W         = $clog2(QUEUE_DEPTH);

    // Operation codes of the input item.
    localparam logic [1:0] OP_VWR = 2'd0;
    localparam logic [1:0] OP_FWR = 2'd1;
    localparam logic [1:0] OP_QRY = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIN_LAT = 2'd0;
    localparam logic [1:0] CFG_COS_LAT = 2'd1;
    localparam logic [1:0] CFG_SIN_LON = 2'd2;
    localparam logic [1:0] CFG_COS_LON = 2'd3;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // One classified command waiting for the back end.
    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] index;
        logic        bad;
        logic [31:0] east;
        logic [31:0] north;
        logic [31:0] up;
        logic [11:0] vtx0;
        logic [11:0] vtx1;
        logic [11:0] vtx2;
    } t_cmd;

endpackage

// ----- src/fnec_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnec_ram: generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module fnec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/fnec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnec_front: input classification and command queue
// Drops items that cause no action and queues the rest in order.
// ----------------------------------------------------------------------------
module fnec_front
    import fnec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [12:0] i_index,
    input  logic [31:0] i_east,
    input  logic [31:0] i_north,
    input  logic [31:0] i_up,
    input  logic [11:0] i_first_vertex,
    input  logic [11:0] i_second_vertex,
    input  logic [11:0] i_third_vertex,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop
);

    t_cmd            r_queue [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;
    t_cmd            cmd;
    logic            keep;
    logic            push;
    logic            pop;
    logic            vtx_ok;
    logic            fac_ok;

    // Classify the incoming item.
    always_comb begin
        vtx_ok    = 32'(i_index) < 32'(VERTEX_DEPTH);
        fac_ok    = 32'(i_index) < 32'(FACET_DEPTH);
        cmd.kind  = i_op;
        cmd.index = i_index;
        cmd.bad   = !fac_ok;
        cmd.east  = i_east;
        cmd.north = i_north;
        cmd.up    = i_up;
        cmd.vtx0  = i_first_vertex;
        cmd.vtx1  = i_second_vertex;
        cmd.vtx2  = i_third_vertex;
        case (i_op)
            OP_VWR:  keep = vtx_ok;
            OP_FWR:  keep = fac_ok;
            OP_QRY:  keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_cnt == (QA_W + 1)'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign pop         = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_queue[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wp] <= cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/fnec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnec_back: store access and facet normal sequencer
// Executes store writes and queries in order, computes the unit normal with
// an iterative square root and divider, and rotates it into ECEF.
// ----------------------------------------------------------------------------
module fnec_back
    import fnec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic               o_degenerate
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FACET = 5'd1;
    localparam logic [4:0] S_V0    = 5'd2;
    localparam logic [4:0] S_V1    = 5'd3;
    localparam logic [4:0] S_V2    = 5'd4;
    localparam logic [4:0] S_EDGE  = 5'd5;
    localparam logic [4:0] S_CROSS = 5'd6;
    localparam logic [4:0] S_CSUB  = 5'd7;
    localparam logic [4:0] S_LEN   = 5'd8;
    localparam logic [4:0] S_SHIFT = 5'd9;
    localparam logic [4:0] S_SQ    = 5'd10;
    localparam logic [4:0] S_SUM   = 5'd11;
    localparam logic [4:0] S_SQRT  = 5'd12;
    localparam logic [4:0] S_DIVI  = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_NSGN  = 5'd15;
    localparam logic [4:0] S_ROT   = 5'd16;
    localparam logic [4:0] S_RSUM  = 5'd17;
    localparam logic [4:0] S_DONE  = 5'd18;

    // Configuration registers.
    logic signed [31:0] r_sin_lat, r_cos_lat, r_sin_lon, r_cos_lon;

    // Sequencer state.
    logic [4:0]  r_state;
    logic [4:0]  r_cnt;
    logic [1:0]  r_row;

    // Memory ports.
    logic            v_we, f_we;
    logic [VA_W-1:0] v_addr;
    logic [FA_W-1:0] f_addr;
    logic [95:0]     v_wdata, v_rdata;
    logic [35:0]     f_wdata, f_rdata;

    // Datapath registers.
    logic [11:0]        r_fvi [3];
    logic [2:0]         r_vok;
    logic signed [31:0] r_v [3][3];
    logic signed [32:0] r_a [3];
    logic signed [32:0] r_b [3];
    logic signed [65:0] r_p [6];
    logic [66:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic [6:0]         r_lmax;
    logic signed [63:0] r_cp [4];
    logic signed [33:0] r_coef [3][3];
    logic [30:0]        r_m [3];
    logic [61:0]        r_sq [3];
    logic [63:0]        r_s;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_drem [3];
    logic [30:0]        r_dlo [3];
    logic [30:0]        r_q [3];
    logic signed [31:0] r_n [3];
    logic signed [65:0] r_rp [3];
    logic signed [31:0] r_res [3];
    logic               r_deg;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_deg;

    logic        load;
    logic        vtx_ok;
    logic [11:0] vtx_idx;
    logic [95:0] v_word;
    logic [66:0] mag_or;
    logic [6:0]  lmax;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_lat <= '0;
            r_cos_lat <= ONE_Q30;
            r_sin_lon <= '0;
            r_cos_lon <= ONE_Q30;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_SIN_LAT: r_sin_lat <= i_cfg_data;
                CFG_COS_LAT: r_cos_lat <= i_cfg_data;
                CFG_SIN_LON: r_sin_lon <= i_cfg_data;
                CFG_COS_LON: r_cos_lon <= i_cfg_data;
                default:     r_sin_lat <= r_sin_lat;
            endcase
        end
    end

    // Store ports: writes from the queue head, reads by the sequencer.
    always_comb begin
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        v_we      = o_cmd_pop && (i_cmd.kind == OP_VWR);
        f_we      = o_cmd_pop && (i_cmd.kind == OP_FWR);
        v_wdata   = {i_cmd.up, i_cmd.north, i_cmd.east};
        f_wdata   = {i_cmd.vtx2, i_cmd.vtx1, i_cmd.vtx0};
        f_addr    = FA_W'(i_cmd.index);
        case (r_state)
            S_FACET: vtx_idx = f_rdata[11:0];
            S_V0:    vtx_idx = r_fvi[1];
            S_V1:    vtx_idx = r_fvi[2];
            default: vtx_idx = 12'(i_cmd.index);
        endcase
        vtx_ok = 32'(vtx_idx) < 32'(VERTEX_DEPTH);
        v_addr = VA_W'(vtx_idx);
    end

    fnec_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_addr  (v_addr),
        .i_wdata (v_wdata),
        .o_rdata (v_rdata)
    );

    fnec_ram #(.WIDTH(36), .DEPTH(FACET_DEPTH)) u_facet_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_addr  (f_addr),
        .i_wdata (f_wdata),
        .o_rdata (f_rdata)
    );

    // A vertex beyond the store reads as the origin.
    always_comb begin
        case (r_state)
            S_V0:    v_word = r_vok[0] ? v_rdata : '0;
            S_V1:    v_word = r_vok[1] ? v_rdata : '0;
            default: v_word = r_vok[2] ? v_rdata : '0;
        endcase
    end

    // Bit length of the largest cross product magnitude.
    always_comb begin
        mag_or = r_mag[0] | r_mag[1] | r_mag[2];
        lmax   = '0;
        for (int i = 0; i < 67; i++) begin
            if (mag_or[i]) begin
                lmax = 7'(i + 1);
            end
        end
    end

    assign load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        logic [34:0]        sq_rem2;
        logic [34:0]        sq_trial;
        logic [61:0]        dvd;
        logic [32:0]        dv_rem2;
        logic signed [66:0] csum;
        logic signed [67:0] rsum;
        logic signed [67:0] rnd;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && (i_cmd.kind == OP_QRY)) begin
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_deg    <= i_cmd.bad;
                        r_state  <= i_cmd.bad ? S_DONE : S_FACET;
                    end
                end
                S_FACET: begin
                    r_fvi[0] <= f_rdata[11:0];
                    r_fvi[1] <= f_rdata[23:12];
                    r_fvi[2] <= f_rdata[35:24];
                    r_vok[0] <= vtx_ok;
                    r_state  <= S_V0;
                end
                S_V0, S_V1, S_V2: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[2'(r_state - S_V0)][k] <= v_word[32*k +: 32];
                    end
                    if (r_state == S_V0) begin
                        r_vok[1] <= vtx_ok;
                        r_state  <= S_V1;
                    end else if (r_state == S_V1) begin
                        r_vok[2] <= vtx_ok;
                        r_state  <= S_V2;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_a[k] <= 33'(r_v[1][k]) - 33'(r_v[0][k]);
                        r_b[k] <= 33'(r_v[2][k]) - 33'(r_v[0][k]);
                    end
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_p[0]  <= r_a[1] * r_b[2];
                    r_p[1]  <= r_a[2] * r_b[1];
                    r_p[2]  <= r_a[2] * r_b[0];
                    r_p[3]  <= r_a[0] * r_b[2];
                    r_p[4]  <= r_a[0] * r_b[1];
                    r_p[5]  <= r_a[1] * r_b[0];
                    r_state <= S_CSUB;
                end
                S_CSUB: begin
                    for (int k = 0; k < 3; k++) begin
                        csum     = 67'(r_p[2*k]) - 67'(r_p[2*k+1]);
                        r_neg[k] <= csum[66];
                        r_mag[k] <= csum[66] ? 67'(-csum) : 67'(csum);
                    end
                    r_state <= S_LEN;
                end
                S_LEN: begin
                    // Centroid trigonometry pair products.
                    r_cp[0] <= r_sin_lat * r_cos_lon;
                    r_cp[1] <= r_cos_lat * r_cos_lon;
                    r_cp[2] <= r_sin_lat * r_sin_lon;
                    r_cp[3] <= r_cos_lat * r_sin_lon;
                    r_lmax  <= lmax;
                    if (mag_or == '0) begin
                        r_deg   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_lmax > 7'd31) begin
                            r_m[k] <= 31'(r_mag[k] >> (r_lmax - 7'd31));
                        end else begin
                            r_m[k] <= 31'(r_mag[k] << (7'd31 - r_lmax));
                        end
                    end
                    r_coef[0][0] <= -(34'(r_sin_lon));
                    r_coef[0][1] <= -(34'((r_cp[0] + 64'sd536870912) >>> 30));
                    r_coef[0][2] <= 34'((r_cp[1] + 64'sd536870912) >>> 30);
                    r_coef[1][0] <= 34'(r_cos_lon);
                    r_coef[1][1] <= -(34'((r_cp[2] + 64'sd536870912) >>> 30));
                    r_coef[1][2] <= 34'((r_cp[3] + 64'sd536870912) >>> 30);
                    r_coef[2][0] <= '0;
                    r_coef[2][1] <= 34'(r_cos_lat);
                    r_coef[2][2] <= 34'(r_sin_lat);
                    r_state      <= S_SQ;
                end
                S_SQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sq[k] <= r_m[k] * r_m[k];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s     <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // One result bit per cycle, two radicand bits consumed.
                    sq_rem2  = {r_rem[32:0], r_s[63:62]};
                    sq_trial = {1'b0, r_root, 2'b01};
                    r_s      <= r_s << 2;
                    if (sq_rem2 >= sq_trial) begin
                        r_rem  <= 34'(sq_rem2 - sq_trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= 34'(sq_rem2);
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    // Rounded dividend; the quotient stays below 2^31.
                    for (int k = 0; k < 3; k++) begin
                        dvd       = {r_m[k], 31'd0} >> 1;
                        dvd       = dvd + 62'(r_root >> 1);
                        r_drem[k] <= 32'(dvd[61:31]);
                        r_dlo[k]  <= dvd[30:0];
                        r_q[k]    <= '0;
                    end
                    r_cnt   <= 5'd30;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        dv_rem2  = {r_drem[k], r_dlo[k][30]};
                        r_dlo[k] <= r_dlo[k] << 1;
                        if (dv_rem2 >= {1'b0, r_root}) begin
                            r_drem[k] <= 32'(dv_rem2 - {1'b0, r_root});
                            r_q[k]    <= {r_q[k][29:0], 1'b1};
                        end else begin
                            r_drem[k] <= 32'(dv_rem2);
                            r_q[k]    <= {r_q[k][29:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_NSGN;
                    end
                end
                S_NSGN: begin
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= r_neg[k] ? -$signed({1'b0, r_q[k]})
                                           : $signed({1'b0, r_q[k]});
                    end
                    r_row   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rp[k] <= r_coef[r_row][k] * r_n[k];
                    end
                    r_state <= S_RSUM;
                end
                S_RSUM: begin
                    rsum = 68'(r_rp[0]) + 68'(r_rp[1]) + 68'(r_rp[2]);
                    rnd  = (rsum + 68'sd536870912) >>> 30;
                    if (rnd > 68'(ONE_Q30)) begin
                        r_res[r_row] <= ONE_Q30;
                    end else if (rnd < -68'(ONE_Q30)) begin
                        r_res[r_row] <= -ONE_Q30;
                    end else begin
                        r_res[r_row] <= 32'(rnd);
                    end
                    r_row <= r_row + 1'b1;
                    r_state <= (r_row == 2'd2) ? S_DONE : S_ROT;
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register: holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_x   <= r_res[0];
            r_out_y   <= r_res[1];
            r_out_z   <= r_res[2];
            r_out_deg <= r_deg;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_normal_x   = r_out_x;
    assign o_normal_y   = r_out_y;
    assign o_normal_z   = r_out_z;
    assign o_degenerate = r_out_deg;

    // The queue head is taken only by an idle sequencer.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE) && i_cmd_valid)
        else $error("command taken while sequencer busy");

    // Store writes never overlap a query in progress.
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_we || f_we) |-> (r_state == S_IDLE))
        else $error("store write during query");

    // A degenerate result carries a zero normal.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_deg) |->
        (r_out_x == '0) && (r_out_y == '0) && (r_out_z == '0))
        else $error("degenerate result with nonzero normal");

    // A newly loaded result follows the end of a query.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid && (r_state == S_IDLE))
        else $error("result load lost");

endmodule

// ----- src/facet_normal_enu_to_ecef_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facet_normal_enu_to_ecef_unit: terrain facet unit normal in ECEF
// Loads vertex and facet stores, then answers facet queries with the unit
// normal of the facet rotated from the tile ENU frame into ECEF.
//
//   Channel  Handshake               Payload
//   input    i_in_valid/o_in_stall   op, index, east, north, up, vertices
//   output   o_out_valid/i_out_stall normal_x/y/z, degenerate
//   config   i_cfg_valid/o_cfg_ready i_cfg_addr, i_cfg_data
//
// A store write completes as the back end takes it from the queue; the time of
// a query is set by the shared bit-serial square root and the three bit-serial
// dividers. A four-entry queue keeps taking items while a query runs. Reset is
// synchronous and acts on control state and the centroid registers only; store
// contents are undefined until written. Output stall holds the result register
// and, once the queue fills, stalls the input.
// ----------------------------------------------------------------------------
module facet_normal_enu_to_ecef_unit
    import fnec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [12:0]        i_index,
    input  logic signed [31:0] i_east,
    input  logic signed [31:0] i_north,
    input  logic signed [31:0] i_up,
    input  logic [11:0]        i_first_vertex,
    input  logic [11:0]        i_second_vertex,
    input  logic [11:0]        i_third_vertex,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic               o_degenerate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_data
);

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // Registers always accept a transfer.
    assign o_cfg_ready = 1'b1;

    fnec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_index         (i_index),
        .i_east          (i_east),
        .i_north         (i_north),
        .i_up            (i_up),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_third_vertex  (i_third_vertex),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_pop       (cmd_pop)
    );

    fnec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_pop    (cmd_pop),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate)
    );

endmodule

// ----- verif/facet_normal_enu_to_ecef_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facet_normal_enu_to_ecef_unit_tb: self-checking bench for the facet normal
// Loads vertex and facet stores through the input channel and queries facet
// normals under several centroid register settings. A predictor in the bench
// computes every expected normal, and a checker compares each output transfer
// field by field. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module facet_normal_enu_to_ecef_unit_tb;
    import fnec_pkg::*;

    localparam logic [1:0] OP_NOP   = 2'd3;
    localparam int         WD_LIMIT = 20000;
    localparam int         DRAIN    = 200;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
    } t_normal;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_op = '0;
    logic [12:0]        i_index = '0;
    logic signed [31:0] i_east = '0;
    logic signed [31:0] i_north = '0;
    logic signed [31:0] i_up = '0;
    logic [11:0]        i_first_vertex = '0;
    logic [11:0]        i_second_vertex = '0;
    logic [11:0]        i_third_vertex = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_normal_x;
    logic signed [31:0] o_normal_y;
    logic signed [31:0] o_normal_z;
    logic               o_degenerate;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_addr = '0;
    logic [31:0]        i_cfg_data = '0;

    facet_normal_enu_to_ecef_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: stores, write tracking and centroid registers.
    logic [31:0] vtx_mem [0:VERTEX_DEPTH-1][0:2];
    logic [11:0] fct_mem [0:FACET_DEPTH-1][0:2];
    bit          vtx_known [0:VERTEX_DEPTH-1];
    bit          fct_known [0:FACET_DEPTH-1];
    int          vtx_list[$];
    int          fct_list[$];
    logic signed [31:0] reg_slat = 32'sd0;
    logic signed [31:0] reg_clat = ONE_Q30;
    logic signed [31:0] reg_slon = 32'sd0;
    logic signed [31:0] reg_clon = ONE_Q30;

    t_normal expected_normals[$];
    int      errors = 0;
    int      items_sent = 0;
    int      normals_seen = 0;
    int      degen_seen = 0;
    bit      quiet = 1'b0;

    // ------------------------------------------------------------------
    // Normal predictor.
    // ------------------------------------------------------------------
    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [63:0] clamp_q30(logic signed [63:0] v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic t_normal predict_normal(logic [12:0] f);
        logic signed [63:0]  p0[3], p1[3], p2[3], ea[3], eb[3], nv[3];
        logic signed [127:0] cr[3];
        logic [127:0]        mg[3];
        logic [63:0]         m[3];
        logic [63:0]         s, len, q;
        logic signed [63:0]  slat, clat, slon, clon, sum;
        logic signed [63:0]  cf[3][3];
        bit                  ng[3];
        int                  lmax, k, j;
        t_normal             r;
        r.x = 0; r.y = 0; r.z = 0; r.degen = 1'b1;
        for (k = 0; k < 3; k++) begin
            p0[k] = $signed(vtx_mem[fct_mem[f][0]][k]);
            p1[k] = $signed(vtx_mem[fct_mem[f][1]][k]);
            p2[k] = $signed(vtx_mem[fct_mem[f][2]][k]);
            ea[k] = p1[k] - p0[k];
            eb[k] = p2[k] - p0[k];
        end
        cr[0] = 128'(ea[1]) * 128'(eb[2]) - 128'(ea[2]) * 128'(eb[1]);
        cr[1] = 128'(ea[2]) * 128'(eb[0]) - 128'(ea[0]) * 128'(eb[2]);
        cr[2] = 128'(ea[0]) * 128'(eb[1]) - 128'(ea[1]) * 128'(eb[0]);
        lmax = 0;
        for (k = 0; k < 3; k++) begin
            ng[k] = cr[k][127];
            mg[k] = ng[k] ? -cr[k] : cr[k];
            for (j = 127; j >= 0; j--) begin
                if (mg[k][j]) begin
                    if (j + 1 > lmax) lmax = j + 1;
                    break;
                end
            end
        end
        if (lmax == 0) return r;
        // Common shift so the largest magnitude has exactly 31 bits.
        s = 0;
        for (k = 0; k < 3; k++) begin
            if (lmax > 31) m[k] = 64'(mg[k] >> (lmax - 31)) & 64'h7FFF_FFFF;
            else m[k] = mg[k][63:0] << (31 - lmax);
            s = s + m[k] * m[k];
        end
        len = isqrt(s);
        for (k = 0; k < 3; k++) begin
            q = ((m[k] << 30) + (len >> 1)) / len;
            nv[k] = ng[k] ? -$signed(q) : $signed(q);
        end
        slat = reg_slat; clat = reg_clat; slon = reg_slon; clon = reg_clon;
        cf[0][0] = -slon; cf[0][1] = -round_q30(slat * clon); cf[0][2] = round_q30(clat * clon);
        cf[1][0] = clon;  cf[1][1] = -round_q30(slat * slon); cf[1][2] = round_q30(clat * slon);
        cf[2][0] = 0;     cf[2][1] = clat;                    cf[2][2] = slat;
        for (k = 0; k < 3; k++) begin
            sum = cf[k][0] * nv[0] + cf[k][1] * nv[1] + cf[k][2] * nv[2];
            sum = clamp_q30(round_q30(sum));
            if (k == 0) r.x = sum[31:0];
            else if (k == 1) r.y = sum[31:0];
            else r.z = sum[31:0];
        end
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic bit facet_ready(int f);
        return fct_known[f] && vtx_known[fct_mem[f][0]] && vtx_known[fct_mem[f][1]]
            && vtx_known[fct_mem[f][2]];
    endfunction

    // ------------------------------------------------------------------
    // Input transfer: one item, with a random idle cycle ahead of it.
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] op, logic [12:0] idx, logic [31:0] e,
                             logic [31:0] n, logic [31:0] u, logic [11:0] v0,
                             logic [11:0] v1, logic [11:0] v2);
        @(negedge i_clk);
        if (!quiet && $urandom_range(99) < 50) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_op = op; i_index = idx; i_east = e; i_north = n; i_up = u;
        i_first_vertex = v0; i_second_vertex = v1; i_third_vertex = v2;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        // Update the predictor on the accepted transfer.
        if (op == OP_VWR && idx < VERTEX_DEPTH) begin
            vtx_mem[idx][0] = e; vtx_mem[idx][1] = n; vtx_mem[idx][2] = u;
            if (!vtx_known[idx]) vtx_list = {vtx_list, int'(idx)};
            vtx_known[idx] = 1'b1;
        end else if (op == OP_FWR) begin
            fct_mem[idx][0] = v0; fct_mem[idx][1] = v1; fct_mem[idx][2] = v2;
            if (!fct_known[idx]) fct_list = {fct_list, int'(idx)};
            fct_known[idx] = 1'b1;
        end else if (op == OP_QRY) begin
            expected_normals = {expected_normals, predict_normal(idx)};
        end
    endtask

    task automatic write_vertex(int idx, logic [31:0] e, logic [31:0] n, logic [31:0] u);
        send_item(OP_VWR, 13'(idx), e, n, u, 12'($urandom), 12'($urandom),
                  12'($urandom));
    endtask

    task automatic write_facet(int idx, int v0, int v1, int v2);
        send_item(OP_FWR, 13'(idx), $urandom, $urandom, $urandom, 12'(v0), 12'(v1),
                  12'(v2));
    endtask

    task automatic query_facet(int idx);
        send_item(OP_QRY, 13'(idx), $urandom, $urandom, $urandom, 12'($urandom),
                  12'($urandom), 12'($urandom));
    endtask

    // Wait until every normal has arrived and the back end has gone quiet.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic signed [31:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_addr = addr; i_cfg_data = val; i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            CFG_SIN_LAT: reg_slat = val;
            CFG_COS_LAT: reg_clat = val;
            CFG_SIN_LON: reg_slon = val;
            default:     reg_clon = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_centroid(logic signed [31:0] slat, logic signed [31:0] clat,
                                logic signed [31:0] slon, logic signed [31:0] clon);
        wait_idle();
        write_reg(CFG_SIN_LAT, slat);
        write_reg(CFG_COS_LAT, clat);
        write_reg(CFG_SIN_LON, slon);
        write_reg(CFG_COS_LON, clon);
    endtask

    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $urandom;
        if (sel < 70) return 32'($signed($urandom_range(2000)) - 1000);
        if (sel < 85) begin
            case ($urandom_range(2))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                default: return 32'h0;
            endcase
        end
        return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endfunction

    function automatic logic signed [31:0] pick_trig();
        case ($urandom_range(4))
            0: return ONE_Q30;
            1: return -ONE_Q30;
            2: return 32'sd0;
            default: return $signed($urandom_range(32'h8000_0000)) - ONE_Q30;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic test_directed();
        // A right triangle in the east-north plane, normal straight up.
        write_vertex(0, 32'd0, 32'd0, 32'd0);
        write_vertex(1, 32'd256, 32'd0, 32'd0);
        write_vertex(2, 32'd0, 32'd256, 32'd0);
        write_facet(0, 0, 1, 2);
        query_facet(0);
        // Extreme coordinates force the widest cross product.
        write_vertex(4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_vertex(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_vertex(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        write_facet(8191, 4095, 3, 4);
        query_facet(8191);
        // Repeated vertex and collinear vertices give a zero cross product.
        write_facet(1, 1, 1, 2);
        query_facet(1);
        write_vertex(5, 32'd512, 32'd0, 32'd0);
        write_facet(2, 0, 1, 5);
        query_facet(2);
        // A tiny facet needs the left shift during normalization.
        write_vertex(6, 32'd1, 32'd0, 32'd0);
        write_vertex(7, 32'd0, 32'd0, 32'd1);
        write_facet(3, 0, 6, 7);
        query_facet(3);
        // A vertex write past the store is ignored, and so is the unused op.
        write_vertex(8191, 32'd9, 32'd9, 32'd9);
        write_vertex(VERTEX_DEPTH, 32'd9, 32'd9, 32'd9);
        send_item(OP_NOP, 13'd0, '1, '1, '1, '1, '1, '1);
        query_facet(0);
    endtask

    task automatic test_random(int count);
        int i, sel, f, tries;
        for (i = 0; i < count; i++) begin
            quiet = (i >= count / 2) && (i < count / 2 + count / 8);
            sel = $urandom_range(99);
            if (sel < 55 && fct_list.size() != 0) begin
                tries = 0;
                do begin
                    f = fct_list[$urandom_range(fct_list.size() - 1)];
                    tries++;
                end while (!facet_ready(f) && tries < 8);
                if (facet_ready(f)) query_facet(f);
            end else if (sel < 75) begin
                if ($urandom_range(3) == 0) f = $urandom_range(VERTEX_DEPTH - 1);
                else f = $urandom_range(31);
                write_vertex(f, pick_coord(), pick_coord(), pick_coord());
            end else if (sel < 95 && vtx_list.size() != 0) begin
                int a, b, c;
                a = vtx_list[$urandom_range(vtx_list.size() - 1)];
                b = vtx_list[$urandom_range(vtx_list.size() - 1)];
                c = vtx_list[$urandom_range(vtx_list.size() - 1)];
                // Now and then a facet references a random vertex, which may be unwritten.
                if ($urandom_range(19) == 0) c = $urandom_range(VERTEX_DEPTH - 1);
                if ($urandom_range(3) == 0) f = $urandom_range(FACET_DEPTH - 1);
                else f = $urandom_range(63);
                write_facet(f, a, b, c);
            end else if (sel < 98) begin
                write_vertex($urandom_range(FACET_DEPTH - 1, VERTEX_DEPTH),
                             $urandom, $urandom, $urandom);
            end else begin
                send_item(OP_NOP, 13'($urandom), $urandom, $urandom, $urandom,
                          12'($urandom), 12'($urandom), 12'($urandom));
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_centroids();
        int p;
        set_centroid(ONE_Q30, ONE_Q30, ONE_Q30, ONE_Q30);
        test_random(90);
        set_centroid(-ONE_Q30, -ONE_Q30, -ONE_Q30, -ONE_Q30);
        test_random(90);
        set_centroid(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        test_random(40);
        for (p = 0; p < 3; p++) begin
            set_centroid(pick_trig(), pick_trig(), pick_trig(), pick_trig());
            test_random(60);
        end
        set_centroid(32'sd0, ONE_Q30, 32'sd0, ONE_Q30);
        test_random(60);
    endtask

    // ------------------------------------------------------------------
    // Output stall: random, with a calm stretch while the input is quiet.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 33);
    end

    // Compare every output transfer with the oldest expected normal.
    always @(posedge i_clk) begin
        t_normal exp_n;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_normals.size() == 0) begin
                $error("unexpected output transfer");
                errors++;
            end else begin
                exp_n = expected_normals.pop_front();
                normals_seen++;
                if (exp_n.degen) degen_seen++;
                if (o_normal_x !== exp_n.x) begin
                    $error("normal_x expected %0d actual %0d", exp_n.x, o_normal_x);
                    errors++;
                end
                if (o_normal_y !== exp_n.y) begin
                    $error("normal_y expected %0d actual %0d", exp_n.y, o_normal_y);
                    errors++;
                end
                if (o_normal_z !== exp_n.z) begin
                    $error("normal_z expected %0d actual %0d", exp_n.z, o_normal_z);
                    errors++;
                end
                if (o_degenerate !== exp_n.degen) begin
                    $error("degenerate expected %0d actual %0d", exp_n.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired with %0d normals outstanding",
                     expected_normals.size());
            $display("facet_normal_enu_to_ecef_unit_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(60);
        test_centroids();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_idle();
        $display("sent %0d items, checked %0d normals (%0d degenerate)",
                 items_sent, normals_seen, degen_seen);
        $display("covered reset, extreme and random centroid registers");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("facet_normal_enu_to_ecef_unit_tb passed");
        end else begin
            $display("facet_normal_enu_to_ecef_unit_tb failed");
        end
        $finish;
    end

endmodule
